>>> sv/nfm_pkg.sv
// Shared types, constants and byte helpers for the n-gram name matcher.
// No dependencies; all other files but nfm_checker use this package.
package nfm_pkg;

   localparam int PATTERN_MAX_DEF = 16;
   localparam int GRAM_MAX_DEF    = 8;
   localparam int CSR_ADDR_W      = 6;
   localparam int CSR_DATA_W      = 64;
   localparam int RSP_DEPTH       = 3;

   localparam logic [16:0] THR_ONE = 17'h10000;

   typedef enum logic [2:0] {
      REG_PATTERN_LOW     = 3'd0,
      REG_PATTERN_HIGH    = 3'd1,
      REG_PATTERN_LENGTH  = 3'd2,
      REG_GRAM_SIZE       = 3'd3,
      REG_SCORE_THRESHOLD = 3'd4,
      REG_CASE_SENSITIVE  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [3:0]  gram;
      logic        case_sens;
      logic [16:0] thr;
   } cfg_type;

   typedef struct packed {
      logic       is_match;
      logic [4:0] hit_count;
      logic [4:0] gram_count;
   } rsp_type;

   function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic case_sens);
      if (!case_sens && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic [4:0] popcount16(input logic [15:0] v);
      logic [2:0] s0;
      logic [2:0] s1;
      logic [2:0] s2;
      logic [2:0] s3;
      s0 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
      s1 = 3'(v[4]) + 3'(v[5]) + 3'(v[6]) + 3'(v[7]);
      s2 = 3'(v[8]) + 3'(v[9]) + 3'(v[10]) + 3'(v[11]);
      s3 = 3'(v[12]) + 3'(v[13]) + 3'(v[14]) + 3'(v[15]);
      return 5'(s0) + 5'(s1) + 5'(s2) + 5'(s3);
   endfunction

endpackage

>>> sv/nfm_csr.sv
// Configuration registers and the pattern-side derivation (folding, clamping,
// distinct gram mask). Depends on nfm_pkg.
module nfm_csr #(
   parameter int PATTERN_MAX = nfm_pkg::PATTERN_MAX_DEF,
   parameter int GRAM_MAX    = nfm_pkg::GRAM_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [nfm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [nfm_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [nfm_pkg::CSR_DATA_W-1:0]  prdata,
   output nfm_pkg::cfg_type                cfg,
   output logic [PATTERN_MAX*8-1:0]        pat_fold,
   output logic [PATTERN_MAX-1:0]          mask
);

   logic [63:0] pat_lo_ff, pat_lo_in;
   logic [63:0] pat_hi_ff, pat_hi_in;
   logic [4:0]  len_ff, len_in;
   logic [3:0]  gram_ff, gram_in;
   logic [16:0] thr_ff, thr_in;
   logic        cs_ff, cs_in;

   nfm_pkg::cfg_type         cfg_ff, cfg_in;
   logic [PATTERN_MAX*8-1:0] pat_fold_ff, pat_fold_in;
   logic [PATTERN_MAX-1:0]   mask_ff, mask_in;

   logic       wr;
   logic [2:0] idx;
   logic [4:0] eff_len;
   logic [3:0] eff_gram;
   logic [7:0] pb [PATTERN_MAX];

   assign wr  = psel && penable && pwrite;
   assign idx = paddr[5:3];

   always_comb begin
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      len_in    = len_ff;
      gram_in   = gram_ff;
      thr_in    = thr_ff;
      cs_in     = cs_ff;
      if (wr) begin
         unique case (idx)
            nfm_pkg::REG_PATTERN_LOW:     pat_lo_in = pwdata;
            nfm_pkg::REG_PATTERN_HIGH:    pat_hi_in = pwdata;
            nfm_pkg::REG_PATTERN_LENGTH:  len_in    = pwdata[4:0];
            nfm_pkg::REG_GRAM_SIZE:       gram_in   = pwdata[3:0];
            nfm_pkg::REG_SCORE_THRESHOLD: thr_in    = pwdata[16:0];
            nfm_pkg::REG_CASE_SENSITIVE:  cs_in     = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         len_ff    <= 5'd1;
         gram_ff   <= 4'd3;
         thr_ff    <= 17'd32768;
         cs_ff     <= 1'b0;
      end else begin
         pat_lo_ff <= pat_lo_in;
         pat_hi_ff <= pat_hi_in;
         len_ff    <= len_in;
         gram_ff   <= gram_in;
         thr_ff    <= thr_in;
         cs_ff     <= cs_in;
      end
   end

   always_comb begin
      unique case (idx)
         nfm_pkg::REG_PATTERN_LOW:     prdata = pat_lo_ff;
         nfm_pkg::REG_PATTERN_HIGH:    prdata = pat_hi_ff;
         nfm_pkg::REG_PATTERN_LENGTH:  prdata = 64'(len_ff);
         nfm_pkg::REG_GRAM_SIZE:       prdata = 64'(gram_ff);
         nfm_pkg::REG_SCORE_THRESHOLD: prdata = 64'(thr_ff);
         nfm_pkg::REG_CASE_SENSITIVE:  prdata = 64'(cs_ff);
         default:                      prdata = '0;
      endcase
   end

   always_comb begin
      logic [127:0] pat_all;
      pat_all = {pat_hi_ff, pat_lo_ff};
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pb[i] = nfm_pkg::fold_byte(pat_all[8*i +: 8], cs_ff);
         pat_fold_in[8*i +: 8] = pb[i];
      end

      if (len_ff == 5'd0) begin
         eff_len = 5'd1;
      end else if (len_ff > 5'(PATTERN_MAX)) begin
         eff_len = 5'(PATTERN_MAX);
      end else begin
         eff_len = len_ff;
      end

      if (gram_ff == 4'd0) begin
         eff_gram = 4'd1;
      end else if (gram_ff > 4'(GRAM_MAX)) begin
         eff_gram = 4'(GRAM_MAX);
      end else begin
         eff_gram = gram_ff;
      end
      if (5'(eff_gram) > eff_len) begin
         eff_gram = 4'(eff_len);
      end

      cfg_in.gram      = eff_gram;
      cfg_in.case_sens = cs_ff;
      cfg_in.thr       = (thr_ff > nfm_pkg::THR_ONE) ? nfm_pkg::THR_ONE : thr_ff;
   end

   always_comb begin
      logic same;
      logic seen_before;
      for (int p = 0; p < PATTERN_MAX; p++) begin
         seen_before = 1'b0;
         for (int q = 0; q < p; q++) begin
            same = 1'b1;
            for (int k = 0; k < GRAM_MAX; k++) begin
               if (p + k < PATTERN_MAX) begin
                  if (4'(k) < eff_gram && pb[p+k] != pb[q+k]) begin
                     same = 1'b0;
                  end
               end
            end
            seen_before = seen_before | same;
         end
         mask_in[p] = (6'(p) + 6'(eff_gram) <= 6'(eff_len)) && !seen_before;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff      <= cfg_in;
      pat_fold_ff <= pat_fold_in;
      mask_ff     <= mask_in;
   end

   assign cfg      = cfg_ff;
   assign pat_fold = pat_fold_ff;
   assign mask     = mask_ff;

endmodule

>>> sv/nfm_match.sv
// Name-side datapath: byte window, gram comparison, hit accumulation and the
// score compare on the last byte. Depends on nfm_pkg.
module nfm_match #(
   parameter int PATTERN_MAX = nfm_pkg::PATTERN_MAX_DEF,
   parameter int GRAM_MAX    = nfm_pkg::GRAM_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_vld,
   input  logic [7:0]               in_char,
   input  logic                     in_has,
   input  logic                     in_last,
   input  nfm_pkg::cfg_type         cfg,
   input  logic [PATTERN_MAX*8-1:0] pat_fold,
   input  logic [PATTERN_MAX-1:0]   mask,
   output logic                     push,
   output nfm_pkg::rsp_type         push_data
);

   localparam int SEEN_W = $clog2(GRAM_MAX + 1);

   logic [7:0]             win_ff [GRAM_MAX];
   logic [7:0]             win_in [GRAM_MAX];
   logic [SEEN_W-1:0]      seen_ff, seen_in;
   logic [PATTERN_MAX-1:0] hits_ff, hits_in;

   logic [7:0]             nw   [GRAM_MAX];
   logic [7:0]             selb [GRAM_MAX];
   logic [SEEN_W-1:0]      seen_next;
   logic [PATTERN_MAX-1:0] hit_vec;
   logic [PATTERN_MAX-1:0] hits_acc;
   logic                   fire;
   logic [4:0]             grams;
   logic [4:0]             hits;
   logic [21:0]            prod;
   logic [21:0]            lhs;

   always_comb begin
      nw[0] = nfm_pkg::fold_byte(in_char, cfg.case_sens);
      for (int i = 1; i < GRAM_MAX; i++) begin
         nw[i] = win_ff[i-1];
      end
      for (int k = 0; k < GRAM_MAX; k++) begin
         selb[k] = 8'h00;
         for (int j = 0; j < GRAM_MAX; j++) begin
            if (5'(j + k) + 5'd1 == 5'(cfg.gram)) begin
               selb[k] = selb[k] | nw[j];
            end
         end
      end
   end

   assign seen_next = (seen_ff < SEEN_W'(GRAM_MAX)) ? seen_ff + SEEN_W'(1) : seen_ff;

   always_comb begin
      logic same;
      for (int p = 0; p < PATTERN_MAX; p++) begin
         same = 1'b1;
         for (int k = 0; k < GRAM_MAX; k++) begin
            if (4'(k) < cfg.gram) begin
               if (p + k < PATTERN_MAX) begin
                  if (pat_fold[8*(p+k) +: 8] != selb[k]) begin
                     same = 1'b0;
                  end
               end else begin
                  same = 1'b0;
               end
            end
         end
         hit_vec[p] = mask[p] && same;
      end
   end

   assign fire     = in_vld && in_has && (4'(seen_next) >= cfg.gram);
   assign hits_acc = hits_ff | (fire ? hit_vec : '0);
   assign grams    = nfm_pkg::popcount16(16'(mask));
   assign hits     = nfm_pkg::popcount16(16'(hits_acc & mask));
   assign prod     = 22'(cfg.thr) * 22'(grams);
   assign lhs      = {1'b0, hits, 16'h0000};

   always_comb begin
      for (int i = 0; i < GRAM_MAX; i++) begin
         win_in[i] = win_ff[i];
      end
      seen_in = seen_ff;
      hits_in = hits_ff;
      if (in_vld) begin
         if (in_has) begin
            for (int i = 0; i < GRAM_MAX; i++) begin
               win_in[i] = nw[i];
            end
            seen_in = seen_next;
         end
         hits_in = hits_acc;
         if (in_last) begin
            seen_in = '0;
            hits_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRAM_MAX; i++) begin
            win_ff[i] <= 8'h00;
         end
         seen_ff <= '0;
         hits_ff <= '0;
      end else begin
         for (int i = 0; i < GRAM_MAX; i++) begin
            win_ff[i] <= win_in[i];
         end
         seen_ff <= seen_in;
         hits_ff <= hits_in;
      end
   end

   assign push                 = in_vld && in_last;
   assign push_data.is_match   = lhs > prod;
   assign push_data.hit_count  = hits;
   assign push_data.gram_count = grams;

endmodule

>>> sv/nfm_rsp_fifo.sv
// Small result queue between the datapath and the result channel.
// Depends on nfm_pkg for the result type and depth.
module nfm_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  nfm_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             out_valid,
   output nfm_pkg::rsp_type out_data,
   output logic [$clog2(nfm_pkg::RSP_DEPTH+1)-1:0] level
);

   localparam int PTR_W = $clog2(nfm_pkg::RSP_DEPTH);
   localparam int LVL_W = $clog2(nfm_pkg::RSP_DEPTH + 1);

   nfm_pkg::rsp_type mem_ff [nfm_pkg::RSP_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [LVL_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(nfm_pkg::RSP_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(nfm_pkg::RSP_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + LVL_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[head_ff];
   assign level     = count_ff;

endmodule

>>> sv/ngram_fuzzy_name_match.sv
// Top level of the n-gram name matcher: input register, datapath, result queue
// and configuration port. Depends on nfm_pkg, nfm_csr, nfm_match, nfm_rsp_fifo.
//
// The name streams in one byte per transaction on req_ (name_char, has_char,
// last_char). A transaction with last_char set yields one result on rsp_:
// the distinct pattern grams hit, the distinct gram count, and is_match.
// A transaction with has_char and last_char both low is dropped quietly; an
// empty final transaction (has_char low, last_char high) reports the hits so far.
// Throughput is one transaction per cycle while req_stall is low. A byte
// taken into the input register is compared in the next cycle against every
// pattern gram at once, and its result, if any, is written to the result queue.
// The result side holds up to three results; req_stall rises only when that
// queue, together with the transaction in the input register, is full, so a
// stalled receiver backs up the sender once two results wait and a third final
// transaction sits in the input register.
// Pattern, gram size, threshold and case folding are written on the csr_ port
// (64-bit registers at 8-byte strides); the derived gram set is computed from
// them and registered again. Reset restores the register defaults and empties
// the queue; req_stall is low straight after reset.
module ngram_fuzzy_name_match #(
   parameter int PATTERN_MAX = nfm_pkg::PATTERN_MAX_DEF,
   parameter int GRAM_MAX    = nfm_pkg::GRAM_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_name_char,
   input  logic                           req_has_char,
   input  logic                           req_last_char,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_is_match,
   output logic [4:0]                     rsp_hit_count,
   output logic [4:0]                     rsp_gram_count,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [nfm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nfm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nfm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int LVL_W = $clog2(nfm_pkg::RSP_DEPTH + 1);

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff;
   logic       in_has_ff;
   logic       in_last_ff;
   logic       accept;

   nfm_pkg::cfg_type         cfg;
   logic [PATTERN_MAX*8-1:0] pat_fold;
   logic [PATTERN_MAX-1:0]   mask;
   logic                     push;
   nfm_pkg::rsp_type         push_data;
   nfm_pkg::rsp_type         out_data;
   logic [LVL_W-1:0]         level;

   assign csr_pready = 1'b1;

   assign req_stall = (3'(level) + 3'(in_vld_ff && in_last_ff)) > 3'(nfm_pkg::RSP_DEPTH - 1);
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_name_char;
         in_has_ff  <= req_has_char;
         in_last_ff <= req_last_char;
      end
   end

   nfm_csr #(
      .PATTERN_MAX (PATTERN_MAX),
      .GRAM_MAX    (GRAM_MAX)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (csr_psel),
      .penable  (csr_penable),
      .pwrite   (csr_pwrite),
      .paddr    (csr_paddr),
      .pwdata   (csr_pwdata),
      .prdata   (csr_prdata),
      .cfg      (cfg),
      .pat_fold (pat_fold),
      .mask     (mask)
   );

   nfm_match #(
      .PATTERN_MAX (PATTERN_MAX),
      .GRAM_MAX    (GRAM_MAX)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (in_vld_ff),
      .in_char   (in_char_ff),
      .in_has    (in_has_ff),
      .in_last   (in_last_ff),
      .cfg       (cfg),
      .pat_fold  (pat_fold),
      .mask      (mask),
      .push      (push),
      .push_data (push_data)
   );

   nfm_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_valid && !rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .level     (level)
   );

   assign rsp_is_match   = out_data.is_match;
   assign rsp_hit_count  = out_data.hit_count;
   assign rsp_gram_count = out_data.gram_count;

endmodule

>>> sv/nfm_checker.sv
// Port-level checks on the result channel of the n-gram name matcher,
// bound to ngram_fuzzy_name_match. Depends on that module's port names.
module nfm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_match,
   input logic [4:0] rsp_hit_count,
   input logic [4:0] rsp_gram_count
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_hits_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_count <= rsp_gram_count)
      else $error("more hits than distinct grams");

   a_grams_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gram_count != 5'd0)
      else $error("result with no distinct grams");

   a_match_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_match |-> rsp_hit_count != 5'd0)
      else $error("match reported without any hit");

endmodule

bind ngram_fuzzy_name_match nfm_checker u_nfm_checker (.*);
